[src/led_matrix_row_scanner_pwm_assert.svh]
// ----------------------------------------------------------------------------
// LED matrix row scanner assertion macros
// Concurrent assertion wrappers used by the scanner back end. Defining
// NO_ASSERTIONS compiles every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_ROW_SCANNER_PWM_ASSERT_SVH
`define LED_MATRIX_ROW_SCANNER_PWM_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Whenever pre holds, post must hold in the same cycle.
`define LMRS_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Whenever pre holds, post must hold in the next cycle.
`define LMRS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`else

`define LMRS_ASSERT_IMPL(label, clk, rst, pre, post)
`define LMRS_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

[src/lmrs_pkg.sv]
// ----------------------------------------------------------------------------
// LED matrix row scanner package
// Shared types and constants for the front end, back end and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmrs_pkg;

   localparam int PIX_W         = 12;
   localparam int SEL_ROWS      = 12;
   localparam int DOT_ROWS      = 4;
   localparam int CHAR_ROW      = 4;
   localparam int BRIGHT_W      = 8;
   localparam int DOT_W         = 4;
   localparam int CSR_DATA_W    = 8;
   localparam int PHASE_W       = 2;
   localparam int BYTES_PER_ROW = 3;

   localparam logic [PIX_W-1:0]    FULL_ROW     = 12'hFFF;
   localparam logic [PIX_W-1:0]    EDGE_ROW     = 12'h801;
   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd128;
   localparam logic [PHASE_W-1:0]  FIRST_PHASE  = 2'd0;
   localparam logic [PHASE_W-1:0]  LAST_PHASE   = 2'd2;

   typedef enum logic {
      CSR_BRIGHTNESS = 1'b0,
      CSR_DOT_MASK   = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_TICK      = 1'b0,
      CMD_WRITE_ROW = 1'b1
   } command_type;

   // Drive state of the matrix and the indicator LEDs.
   typedef struct packed {
      logic             char_on;
      logic [DOT_W-1:0] dot;
      logic             led;
   } drive_type;

   // One classified request handed from the front end to the back end.
   typedef struct packed {
      logic [BYTES_PER_ROW-1:0][7:0] byte_seq;
      logic                          wrap;
      drive_type                     drive;
   } job_type;

   // One response as held in the output register.
   typedef struct packed {
      logic      last;
      logic      byte_valid;
      logic [7:0] shift_byte;
      logic      clear;
      logic      latch;
      drive_type drive;
   } rsp_type;

endpackage

`default_nettype wire

[src/lmrs_front.sv]
// ----------------------------------------------------------------------------
// LED matrix row scanner front end
// Holds the frame store, PWM counter, scan row and drive state. Every accepted
// request updates the state and leaves one job for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmrs_front #(
   parameter int ROWS     = 12,
   parameter int PWM_BITS = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire lmrs_pkg::csr_index_type       csr_addr,
   input  wire [lmrs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire                                accept,
   input  wire lmrs_pkg::command_type         command,
   input  wire [3:0]                          row_index,
   input  wire [lmrs_pkg::PIX_W-1:0]          row_pixels,
   output lmrs_pkg::job_type                  job
);

   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int EXT_W = 5;
   localparam int CMP_W = (PWM_BITS > lmrs_pkg::BRIGHT_W) ? PWM_BITS : lmrs_pkg::BRIGHT_W;

   logic [lmrs_pkg::PIX_W-1:0]    frame_ff [ROWS];
   logic [lmrs_pkg::PIX_W-1:0]    frame_in [ROWS];
   logic [ROW_W-1:0]              row_ff, row_in, row_step;
   logic [PWM_BITS-1:0]           count_ff, count_in, count_inc;
   lmrs_pkg::drive_type           drive_ff, drive_in, drive_tick;
   logic [lmrs_pkg::BRIGHT_W-1:0] brightness_ff, brightness_in;
   logic [lmrs_pkg::DOT_W-1:0]    dot_mask_ff, dot_mask_in;
   logic                          wrap, match;
   logic [EXT_W-1:0]              row_ext;
   logic [lmrs_pkg::PIX_W-1:0]    px, sel;
   logic [EXT_W-1:0]              sel_pos;

   always_comb begin
      brightness_in = brightness_ff;
      dot_mask_in   = dot_mask_ff;
      if (csr_we) begin
         case (csr_addr)
            lmrs_pkg::CSR_BRIGHTNESS: brightness_in = csr_wdata;
            lmrs_pkg::CSR_DOT_MASK:   dot_mask_in   = csr_wdata[lmrs_pkg::DOT_W-1:0];
            default:                  brightness_in = brightness_ff;
         endcase
      end
   end

   always_comb begin
      count_inc = count_ff + 1'b1;
      wrap      = (count_inc == '0);
      match     = (CMP_W'(count_inc) == CMP_W'(brightness_ff));
      row_step  = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + 1'b1;
      row_ext   = EXT_W'(row_step);
      px        = frame_ff[row_step];

      // Active-low row select; rows past the select lines leave all bits high.
      sel     = lmrs_pkg::FULL_ROW;
      sel_pos = EXT_W'(lmrs_pkg::SEL_ROWS - 1) - row_ext;
      if (row_ext < EXT_W'(lmrs_pkg::SEL_ROWS)) begin
         sel[sel_pos[3:0]] = 1'b0;
      end

      drive_tick = drive_ff;
      if (wrap) begin
         drive_tick.led = 1'b1;
         if (row_ext < EXT_W'(lmrs_pkg::DOT_ROWS) && dot_mask_ff[row_ext[1:0]]) begin
            drive_tick.dot[row_ext[1:0]] = 1'b1;
         end
         if (row_ext == EXT_W'(lmrs_pkg::CHAR_ROW)) begin
            drive_tick.char_on = 1'b1;
         end
      end
      // The compare follows the wrap, so a brightness of zero stays dark.
      if (match) begin
         drive_tick = '0;
      end

      job.drive       = drive_ff;
      job.wrap        = 1'b0;
      job.byte_seq[0] = px[11:4];
      job.byte_seq[1] = {px[3:0], sel[11:8]};
      job.byte_seq[2] = sel[7:0];
      if (command == lmrs_pkg::CMD_TICK) begin
         job.drive = drive_tick;
         job.wrap  = wrap;
      end

      frame_in = frame_ff;
      row_in   = row_ff;
      count_in = count_ff;
      drive_in = drive_ff;
      if (accept) begin
         if (command == lmrs_pkg::CMD_WRITE_ROW) begin
            if ({1'b0, row_index} < EXT_W'(ROWS)) begin
               frame_in[row_index[ROW_W-1:0]] = row_pixels;
            end
         end else begin
            count_in = count_inc;
            drive_in = drive_tick;
            if (wrap) begin
               row_in = row_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            frame_ff[r] <= ((r == 0) || (r == ROWS - 1)) ? lmrs_pkg::FULL_ROW
                                                        : lmrs_pkg::EDGE_ROW;
         end
         row_ff        <= ROW_W'(ROWS - 1);
         count_ff      <= '0;
         drive_ff      <= '0;
         brightness_ff <= lmrs_pkg::BRIGHT_RESET;
         dot_mask_ff   <= '0;
      end else begin
         frame_ff      <= frame_in;
         row_ff        <= row_in;
         count_ff      <= count_in;
         drive_ff      <= drive_in;
         brightness_ff <= brightness_in;
         dot_mask_ff   <= dot_mask_in;
      end
   end

endmodule

`default_nettype wire

[src/lmrs_queue.sv]
// ----------------------------------------------------------------------------
// LED matrix row scanner job queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmrs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire [WIDTH-1:0]  din,
   input  wire              pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[src/lmrs_back.sv]
// ----------------------------------------------------------------------------
// LED matrix row scanner back end
// Expands each queued job into one status response or three shift bytes and
// holds the current response in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_matrix_row_scanner_pwm_assert.svh"

module lmrs_back (
   input  wire                clock,
   input  wire                reset,
   input  wire lmrs_pkg::job_type head,
   input  wire                head_valid,
   output logic               pop,
   input  wire                rsp_ready,
   output logic               rsp_valid,
   output lmrs_pkg::rsp_type  rsp
);

   logic [lmrs_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                         valid_ff, valid_in;
   lmrs_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         load, phase_last;

   always_comb begin
      load       = !valid_ff || rsp_ready;
      phase_last = !head.wrap || (phase_ff == lmrs_pkg::LAST_PHASE);
      pop        = load && head_valid && phase_last;

      rsp_in.drive      = head.drive;
      rsp_in.latch      = head.wrap && (phase_ff == lmrs_pkg::FIRST_PHASE);
      rsp_in.clear      = head.wrap && (phase_ff == lmrs_pkg::FIRST_PHASE);
      rsp_in.byte_valid = head.wrap;
      rsp_in.shift_byte = head.wrap ? head.byte_seq[phase_ff] : 8'd0;
      rsp_in.last       = phase_last;

      valid_in = valid_ff;
      phase_in = phase_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            phase_in = phase_last ? lmrs_pkg::FIRST_PHASE : phase_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= lmrs_pkg::FIRST_PHASE;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   // A byte sequence in progress always has its wrap job at the queue head.
   `LMRS_ASSERT_IMPL(a_phase_needs_wrap, clock, reset, phase_ff != lmrs_pkg::FIRST_PHASE, head_valid && head.wrap)
   `LMRS_ASSERT_IMPL(a_phase_bound, clock, reset, 1'b1, phase_ff <= lmrs_pkg::LAST_PHASE)
   // Latch and clear only open a three-byte run.
   `LMRS_ASSERT_IMPL(a_pulse_first, clock, reset, valid_ff && rsp_ff.latch, rsp_ff.byte_valid && !rsp_ff.last)
   `LMRS_ASSERT_NEXT(a_wrap_steps, clock, reset, load && head_valid && !phase_last, phase_ff != lmrs_pkg::FIRST_PHASE)

endmodule

`default_nettype wire

[src/led_matrix_row_scanner_pwm.sv]
// ----------------------------------------------------------------------------
// LED matrix row scanner with PWM dimming
// Multiplexed row scan of a ROWS x 12 LED matrix with shift-register output.
// ----------------------------------------------------------------------------
// Usage: each request on the req_ channel is either a PWM tick (req_tuser = 0)
// or a frame row write (req_tuser = 1, row index and pixels in req_tdata).
// Every request produces responses on the rsp_ channel: one status response
// for a row write or a plain tick, and three shift bytes with latch and clear
// on the first when the PWM counter wraps. rsp_tlast marks the last response
// of a request; rsp_tuser says that rsp_tdata carries a byte to shift out.
// The csr_ port writes brightness (index 0) and the dot mask (index 1).
// A request accepted into the job queue has its first response loaded into
// the output register once the jobs ahead of it are done and the output
// register is free to load. Throughput: one request per cycle; a wrap keeps
// the back end busy for its three shift bytes, and the job queue of
// QUEUE_DEPTH entries absorbs that, so req_tready drops only when the queue
// is full.
// Reset: synchronous, active high. It loads the border pattern into the
// frame store, brightness 128, dot mask 0, PWM counter 0, scan row ROWS-1
// and all drives off. When the receiver stalls, the response is held in the
// output register and requests keep entering until the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_row_scanner_pwm #(
   parameter int ROWS        = 12,
   parameter int PWM_BITS    = 8,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   // [3:0] row_index, [15:4] row_pixels
   input  wire [15:0] req_tdata,
   // [0] command
   input  wire        req_tuser,
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   // [0] led_enable, [4:1] dot_enable, [5] char_enable, [6] latch_pulse,
   // [7] clear_pulse, [15:8] shift_byte
   output logic [15:0] rsp_tdata,
   // [0] byte_valid
   output logic       rsp_tuser,
   output logic       rsp_tlast,
   input  wire        csr_we,
   input  wire        csr_addr,
   input  wire [7:0]  csr_wdata
);

   localparam int JOB_W = $bits(lmrs_pkg::job_type);

   lmrs_pkg::job_type job_push, job_head;
   logic [JOB_W-1:0]  head_bits;
   logic              accept, queue_full, queue_empty, pop;
   logic              rsp_valid;
   lmrs_pkg::rsp_type rsp;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !queue_full;

   // Front end: state update and classification of each request.
   lmrs_front #(
      .ROWS     (ROWS),
      .PWM_BITS (PWM_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (lmrs_pkg::csr_index_type'(csr_addr)),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .command    (lmrs_pkg::command_type'(req_tuser)),
      .row_index  (req_tdata[3:0]),
      .row_pixels (req_tdata[15:4]),
      .job        (job_push)
   );

   // Jobs wait here while the back end shifts out a row.
   lmrs_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .din   (job_push),
      .pop   (pop),
      .dout  (head_bits),
      .full  (queue_full),
      .empty (queue_empty)
   );

   assign job_head = lmrs_pkg::job_type'(head_bits);

   // Back end: response sequencing and the output register.
   lmrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (job_head),
      .head_valid (!queue_empty),
      .pop        (pop),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {rsp.shift_byte, rsp.clear, rsp.latch, rsp.drive.char_on,
                        rsp.drive.dot, rsp.drive.led};
   assign rsp_tuser  = rsp.byte_valid;
   assign rsp_tlast  = rsp.last;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scanner testbench
// Sends row writes and PWM ticks in random bursts and stalls the response side
// on a changing pattern. A scan model predicts every response, and the monitor
// checks each accepted response field by field in order.
// ----------------------------------------------------------------------------

module testbench;

   localparam int SCAN_ROWS       = lmrs_pkg::SEL_ROWS;
   localparam int WRAP_TICKS      = 256;
   localparam int FIRST_TICKS     = 190;
   localparam int POST_WRAP_TICKS = 4;
   localparam int DIRECTED_TICKS  = 2;
   localparam int DRAIN_WAIT      = 20;
   localparam int MAX_REPORT      = 10;

   // One request as it travels on the req_ channel.
   typedef struct packed {
      lmrs_pkg::command_type      cmd;
      logic [3:0]                 row;
      logic [lmrs_pkg::PIX_W-1:0] pix;
   } scan_req_type;

   // One response, with the fields of rsp_tdata, rsp_tuser and rsp_tlast.
   typedef struct packed {
      logic                       led;
      logic [lmrs_pkg::DOT_W-1:0] dot;
      logic                       chr;
      logic                       latch;
      logic                       clr;
      logic                       bvalid;
      logic [7:0]                 sbyte;
      logic                       last;
   } scan_rsp_type;

   // Receiver stall patterns; each one runs for a random stretch of cycles.
   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_PERIODIC
   } ready_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [15:0] rsp_tdata;
   wire         rsp_tuser;
   wire         rsp_tlast;
   logic        csr_we     = 1'b0;
   logic        csr_addr   = 1'b0;
   logic [7:0]  csr_wdata  = '0;

   led_matrix_row_scanner_pwm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard ceiling on the run. The slowest legal run stays far below it.
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Scan model: its own copy of the frame store, counters and drive state.
   // ------------------------------------------------------------------------
   logic [lmrs_pkg::PIX_W-1:0]    frame_rows [SCAN_ROWS];
   logic [3:0]                    scan_row;
   logic [7:0]                    pwm_cnt;
   logic                          drive_led;
   logic [lmrs_pkg::DOT_W-1:0]    dot_drv;
   logic                          char_drv;
   logic [lmrs_pkg::BRIGHT_W-1:0] bright_reg;
   logic [lmrs_pkg::DOT_W-1:0]    dot_mask_reg;

   scan_rsp_type due_rsp_q [$];
   scan_req_type req_backlog_q [$];

   int req_count     = 0;
   int rsp_count     = 0;
   int scan_count    = 0;
   int setting_count = 0;
   int mismatches    = 0;

   initial begin
      for (int i = 0; i < SCAN_ROWS; i++) begin
         frame_rows[i] = lmrs_pkg::EDGE_ROW;
      end
      frame_rows[0]           = lmrs_pkg::FULL_ROW;
      frame_rows[SCAN_ROWS-1] = lmrs_pkg::FULL_ROW;
      scan_row     = 4'(SCAN_ROWS - 1);
      pwm_cnt      = '0;
      drive_led    = 1'b0;
      dot_drv      = '0;
      char_drv     = 1'b0;
      bright_reg   = lmrs_pkg::BRIGHT_RESET;
      dot_mask_reg = '0;
   end

   // Works out the responses of one accepted request and queues them.
   task automatic scan_predict(input scan_req_type rq);
      scan_rsp_type               r;
      logic [lmrs_pkg::PIX_W-1:0] px;
      logic [lmrs_pkg::PIX_W-1:0] sel;
      logic                       wrap;
      logic [7:0]                 b1, b2, b3;
      r    = '0;
      wrap = 1'b0;
      b1   = '0;
      b2   = '0;
      b3   = '0;
      if (rq.cmd == lmrs_pkg::CMD_WRITE_ROW) begin
         // Rows past the bottom of the matrix are dropped without a trace.
         if (rq.row < SCAN_ROWS) begin
            frame_rows[rq.row] = rq.pix;
         end
      end else begin
         pwm_cnt = pwm_cnt + 8'd1;
         wrap    = (pwm_cnt == 8'd0);
         if (wrap) begin
            drive_led = 1'b1;
            scan_row  = (scan_row == SCAN_ROWS - 1) ? 4'd0 : scan_row + 4'd1;
            if (scan_row < lmrs_pkg::DOT_ROWS && dot_mask_reg[scan_row[1:0]]) begin
               dot_drv[scan_row[1:0]] = 1'b1;
            end
            if (scan_row == lmrs_pkg::CHAR_ROW) begin
               char_drv = 1'b1;
            end
            px  = frame_rows[scan_row];
            sel = lmrs_pkg::FULL_ROW;
            sel[11 - scan_row] = 1'b0;
            b1  = px[11:4];
            b2  = {px[3:0], sel[11:8]};
            b3  = sel[7:0];
            scan_count++;
         end
         // The compare comes after the wrap, so brightness zero stays dark and
         // every dot goes off, not just the one of the current row.
         if (pwm_cnt == bright_reg) begin
            drive_led = 1'b0;
            dot_drv   = '0;
            char_drv  = 1'b0;
         end
      end
      r.led = drive_led;
      r.dot = dot_drv;
      r.chr = char_drv;
      if (!wrap) begin
         r.last = 1'b1;
         due_rsp_q.push_back(r);
      end else begin
         r.latch  = 1'b1;
         r.clr    = 1'b1;
         r.bvalid = 1'b1;
         r.sbyte  = b1;
         due_rsp_q.push_back(r);
         r.latch  = 1'b0;
         r.clr    = 1'b0;
         r.sbyte  = b2;
         due_rsp_q.push_back(r);
         r.sbyte  = b3;
         r.last   = 1'b1;
         due_rsp_q.push_back(r);
      end
   endtask

   function automatic string fmt_rsp(input scan_rsp_type r);
      return $sformatf("led=%0b dot=%h chr=%0b lat=%0b clr=%0b vld=%0b byte=%h last=%0b",
                       r.led, r.dot, r.chr, r.latch, r.clr, r.bvalid, r.sbyte, r.last);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: bursts of requests from the backlog with random gaps in between.
   // A request is predicted at the edge where it is accepted.
   // ------------------------------------------------------------------------
   scan_req_type req_on_bus = '0;
   int           burst_left = 1;
   int           gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            scan_predict(req_on_bus);
            req_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (req_backlog_q.size() > 0) begin
               req_on_bus = req_backlog_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= req_on_bus.cmd;
               req_tdata  <= {req_on_bus.pix, req_on_bus.row};
               burst_left--;
               if (burst_left <= 0) begin
                  // Some bursts run straight into the next one with no gap.
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each accepted response against the oldest prediction and
   // moves rsp_tready through its stall patterns.
   // ------------------------------------------------------------------------
   ready_mode_type ready_mode = RDY_ALWAYS;
   int             mode_left  = 0;
   int             mode_tick  = 0;
   scan_rsp_type   seen_rsp;
   scan_rsp_type   want_rsp;
   logic           bad;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp.led    = rsp_tdata[0];
         seen_rsp.dot    = rsp_tdata[4:1];
         seen_rsp.chr    = rsp_tdata[5];
         seen_rsp.latch  = rsp_tdata[6];
         seen_rsp.clr    = rsp_tdata[7];
         seen_rsp.sbyte  = rsp_tdata[15:8];
         seen_rsp.bvalid = rsp_tuser;
         seen_rsp.last   = rsp_tlast;
         rsp_count++;
         if (due_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORT) begin
               $display("tb: response %0d arrived with nothing predicted: %s",
                        rsp_count, fmt_rsp(seen_rsp));
            end
         end else begin
            want_rsp = due_rsp_q.pop_front();
            bad = (seen_rsp.led    !== want_rsp.led)    ||
                  (seen_rsp.dot    !== want_rsp.dot)    ||
                  (seen_rsp.chr    !== want_rsp.chr)    ||
                  (seen_rsp.latch  !== want_rsp.latch)  ||
                  (seen_rsp.clr    !== want_rsp.clr)    ||
                  (seen_rsp.bvalid !== want_rsp.bvalid) ||
                  (seen_rsp.sbyte  !== want_rsp.sbyte)  ||
                  (seen_rsp.last   !== want_rsp.last);
            if (bad) begin
               mismatches++;
               if (mismatches <= MAX_REPORT) begin
                  $display("tb: response %0d mismatch", rsp_count);
                  $display("   expected %s", fmt_rsp(want_rsp));
                  $display("   actual   %s", fmt_rsp(seen_rsp));
               end
            end
         end
      end
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 250);
      end else begin
         mode_left--;
      end
      mode_tick++;
      case (ready_mode)
         RDY_ALWAYS:   rsp_tready <= 1'b1;
         RDY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         RDY_SPARSE:   rsp_tready <= ($urandom_range(0, 2) == 0);
         default:      rsp_tready <= (mode_tick % 4 == 0);
      endcase
   end

   // ------------------------------------------------------------------------
   // Stimulus and phase control.
   // ------------------------------------------------------------------------
   task automatic push_req(input lmrs_pkg::command_type cmd, input logic [3:0] row,
                           input logic [lmrs_pkg::PIX_W-1:0] pix);
      scan_req_type rq;
      rq.cmd = cmd;
      rq.row = row;
      rq.pix = pix;
      req_backlog_q.push_back(rq);
   endtask

   // Registers change only while nothing is queued, on the bus or predicted.
   task automatic wait_drained();
      while (req_backlog_q.size() != 0 || req_tvalid || due_rsp_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input lmrs_pkg::csr_index_type idx, input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == lmrs_pkg::CSR_BRIGHTNESS) begin
         bright_reg = value;
      end else begin
         dot_mask_reg = value[lmrs_pkg::DOT_W-1:0];
      end
   endtask

   // Nearly all ticks, so the PWM counter reaches its wrap; the rest are row
   // writes, a few of them past the last row.
   task automatic fill_random(input int ticks_wanted);
      int ticks;
      int pick;
      ticks = 0;
      while (ticks < ticks_wanted) begin
         pick = $urandom_range(0, 99);
         if (pick < 98) begin
            push_req(lmrs_pkg::CMD_TICK, 4'($urandom), 12'($urandom));
            ticks++;
         end else if (pick < 99) begin
            push_req(lmrs_pkg::CMD_WRITE_ROW, 4'($urandom_range(0, SCAN_ROWS - 1)),
                     12'($urandom));
         end else begin
            push_req(lmrs_pkg::CMD_WRITE_ROW, 4'($urandom_range(0, 15)), 12'($urandom));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: pixel extremes, the top and bottom rows, writes past
      // the last row, then a run of ticks that stops short of the first wrap.
      push_req(lmrs_pkg::CMD_WRITE_ROW, 4'd0,  12'hA5A);
      push_req(lmrs_pkg::CMD_WRITE_ROW, 4'd11, 12'hFFF);
      push_req(lmrs_pkg::CMD_WRITE_ROW, 4'd12, 12'h123);
      push_req(lmrs_pkg::CMD_WRITE_ROW, 4'd15, 12'hFFF);
      push_req(lmrs_pkg::CMD_TICK,      4'd15, 12'hFFF);
      push_req(lmrs_pkg::CMD_WRITE_ROW, 4'd1,  12'h800);
      push_req(lmrs_pkg::CMD_WRITE_ROW, 4'd4,  12'h5A5);
      push_req(lmrs_pkg::CMD_WRITE_ROW, 4'd14, 12'h000);
      push_req(lmrs_pkg::CMD_TICK,      4'd0,  12'h000);
      fill_random(FIRST_TICKS);
      wait_drained();
      setting_count++;

      // Low brightness with the row 0 dot enabled: the wrap scans row 0 and
      // lights its dot, and the compare a few ticks later turns all off.
      write_reg(lmrs_pkg::CSR_BRIGHTNESS, 8'd3);
      write_reg(lmrs_pkg::CSR_DOT_MASK, 8'h01);
      setting_count++;
      @(negedge clock);
      fill_random(WRAP_TICKS - DIRECTED_TICKS - FIRST_TICKS + POST_WRAP_TICKS);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      $display("tb: %0d requests and %0d responses checked under %0d register settings",
               req_count, rsp_count, setting_count);
      $display("tb: %0d row scans, %0d mismatches", scan_count, mismatches);
      if (mismatches == 0 && due_rsp_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/lmrs_pkg.sv
src/lmrs_front.sv
src/lmrs_queue.sv
src/lmrs_back.sv
src/led_matrix_row_scanner_pwm.sv
tb/testbench.sv
